// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge while reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/cdq_pkg.sv -----
package cdq_pkg;

    // storage depth, the pointer width derived from it and the other widths
    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int OP_W   = 3;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_PEEK      = 3'd4
    } op_t;

    // request into the slot memory
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr_a;
        logic [PTR_W-1:0]  raddr_b;
    } ram_req_t;

endpackage

// ----- sv/circular_deque.sv -----
// circular_deque: double-ended queue of signed 32-bit values in a ring memory
//
// s_ channel: one transfer per operation; tdata carries op (insert front,
// insert rear, delete front, delete rear, peek) and the value to insert.
// m_ channel: one transfer per operation with ok, the front and rear values
// (-1 when empty) and the empty and full flags.
// apb port: register 0 is capacity; writing it empties the deque. write it
// only while no operation is in flight.
//
// the slot memory is written in the accept cycle, read in the next, and its
// registered data loaded into the output register in the load step once that
// register is free; a new operation is taken only after the load step.
// the block takes the next input while a result waits in the output
// register; a result that is not taken holds the block in its load step.
// reset (synchronous, active low) empties the deque and sets capacity to
// 1024; the slot memory needs no clearing since only written slots are read.
module circular_deque (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[2:0], value[34:3], zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // ok[0], front_value[32:1], rear_value[64:33],
                                   // is_empty[65], is_full[66], zero pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W  = cdq_pkg::PTR_W;
    localparam int DATA_W = cdq_pkg::DATA_W;
    localparam int CAP_W  = cdq_pkg::CAP_W;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
        return (p == last) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                   input logic [PTR_W-1:0] last);
        return (p == '0) ? last : p - PTR_W'(1);
    endfunction

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    front_reg, front_next;
    logic [PTR_W-1:0]    rear_reg, rear_next;
    logic [PTR_W-1:0]    last_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic                ok_reg, ok_next;
    logic                m_tvalid_reg;
    logic [71:0]         m_tdata_reg;

    logic                in_xfer;
    logic                cfg_wr;
    logic [31:0]         cap_wide;
    logic [PTR_W-1:0]    last_cfg;
    logic                empty_now, full_now;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   in_value;
    cdq_pkg::ram_req_t   ram_req;
    logic [DATA_W-1:0]   rd_front, rd_rear;
    logic                out_free;
    logic                empty_out, full_out;
    logic [DATA_W-1:0]   front_out, rear_out;

    // handshakes
    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign in_xfer  = s_tvalid && s_tready;
    assign in_value = s_tdata[34:3];
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign cap_wide = 32'(pwdata[CAP_W-1:0]);
    assign last_cfg = (cap_wide == 32'd0)                ? PTR_W'(1) :
                      (cap_wide > 32'(cdq_pkg::DEPTH))   ? PTR_W'(cdq_pkg::DEPTH) :
                                                           PTR_W'(cap_wide);
    assign prdata   = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

    // pointer update and slot write for the incoming operation
    assign empty_now = (front_reg == rear_reg);
    assign full_now  = (step_up(rear_reg, last_reg) == front_reg);

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        ok_next    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        case (cdq_pkg::op_t'(s_tdata[2:0]))
            cdq_pkg::OP_INS_FRONT: begin
                if (!full_now) begin
                    wr_en      = 1'b1;
                    wr_addr    = front_reg;
                    front_next = step_down(front_reg, last_reg);
                    ok_next    = 1'b1;
                end
            end
            cdq_pkg::OP_INS_REAR: begin
                if (!full_now) begin
                    rear_next = step_up(rear_reg, last_reg);
                    wr_en     = 1'b1;
                    wr_addr   = step_up(rear_reg, last_reg);
                    ok_next   = 1'b1;
                end
            end
            cdq_pkg::OP_DEL_FRONT: begin
                if (!empty_now) begin
                    front_next = step_up(front_reg, last_reg);
                    ok_next    = 1'b1;
                end
            end
            cdq_pkg::OP_DEL_REAR: begin
                if (!empty_now) begin
                    rear_next = step_down(rear_reg, last_reg);
                    ok_next   = 1'b1;
                end
            end
            cdq_pkg::OP_PEEK: begin
                ok_next = 1'b1;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    // memory request: write on accept, read both ends in the next cycle
    always_comb begin
        ram_req.we      = in_xfer && wr_en;
        ram_req.waddr   = wr_addr;
        ram_req.wdata   = in_value;
        ram_req.re      = (state_reg == ST_READ);
        ram_req.raddr_a = step_up(front_reg, last_reg);
        ram_req.raddr_b = rear_reg;
    end

    cdq_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rdata_a (rd_front),
        .rdata_b (rd_rear)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            cap_reg   <= CAP_W'(cdq_pkg::DEPTH);
            last_reg  <= PTR_W'(cdq_pkg::DEPTH);
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                cap_reg   <= pwdata[CAP_W-1:0];
                last_reg  <= last_cfg;
                front_reg <= '0;
                rear_reg  <= '0;
            end else if (in_xfer) begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
            end
        end
    end

    // status of the operation in flight
    always_ff @(posedge aclk) begin
        if (in_xfer) ok_reg <= ok_next;
    end

    // result assembly from registered memory data
    assign empty_out = (front_reg == rear_reg);
    assign full_out  = (step_up(rear_reg, last_reg) == front_reg);
    assign front_out = empty_out ? '1 : rd_front;
    assign rear_out  = empty_out ? '1 : rd_rear;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_LOAD) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_LOAD) && out_free) begin
            m_tdata_reg <= {5'b0, full_out, empty_out, rear_out, front_out, ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/cdq_ram.sv -----
module cdq_ram (
    input  logic                       aclk,
    input  cdq_pkg::ram_req_t          req,
    output logic [cdq_pkg::DATA_W-1:0] rdata_a,
    output logic [cdq_pkg::DATA_W-1:0] rdata_b
);

    logic [cdq_pkg::DATA_W-1:0] slot_mem [cdq_pkg::DEPTH+1];
    logic [cdq_pkg::DATA_W-1:0] rdata_a_reg;
    logic [cdq_pkg::DATA_W-1:0] rdata_b_reg;

    // one write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            slot_mem[req.waddr] <= req.wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_a_reg <= slot_mem[req.raddr_a];
            rdata_b_reg <= slot_mem[req.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- sv/cdq_check.sv -----
`include "assert_macros.svh"

module cdq_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // no result right after reset
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a stalled result holds its payload
    `ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // one operation in flight at a time
    `ASSERT_RST(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    // empty and full never together
    `ASSERT_RST(a_flags, aclk, aresetn, m_tvalid |-> !(m_tdata[65] && m_tdata[66]), "empty and full both set")

    // an empty deque reports -1 at both ends
    `ASSERT_RST(a_empty_vals, aclk, aresetn, m_tvalid && m_tdata[65] |-> m_tdata[64:1] == {64{1'b1}}, "empty values not -1")

endmodule

bind circular_deque cdq_check u_cdq_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb_circular_deque.sv -----
// one result transfer as it appears in m_tdata, msb first
typedef struct packed {
    logic        is_full;
    logic        is_empty;
    logic [31:0] rear_value;
    logic [31:0] front_value;
    logic        ok;
} deque_status_t;

// tracks the deque contents and the status each operation must report
class deque_scoreboard;
    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    logic [31:0]   slot_mem [cdq_pkg::DEPTH+1];
    int unsigned   front_ptr;
    int unsigned   rear_ptr;
    int unsigned   ring_len;
    deque_status_t expected_status_q [$];
    int unsigned   mismatches;

    function new();
        foreach (slot_mem[i]) slot_mem[i] = '0;
        mismatches = 0;
        set_capacity(cdq_pkg::DEPTH);
    endfunction

    // capacity write clamps to 1..DEPTH and empties the deque
    function void set_capacity(int unsigned cap);
        int unsigned held = cap;
        if (held < 1) held = 1;
        if (held > cdq_pkg::DEPTH) held = cdq_pkg::DEPTH;
        ring_len  = held + 1;
        front_ptr = 0;
        rear_ptr  = 0;
    endfunction

    function int unsigned slot_after(int unsigned p);
        return (p + 1 >= ring_len) ? 0 : p + 1;
    endfunction

    function int unsigned slot_before(int unsigned p);
        return (p == 0) ? ring_len - 1 : p - 1;
    endfunction

    // apply one accepted operation and queue the status it should produce
    function void note_op(logic [2:0] op, logic [31:0] val);
        deque_status_t st;
        bit            was_empty;
        bit            was_full;
        was_empty = (front_ptr == rear_ptr);
        was_full  = (slot_after(rear_ptr) == front_ptr);
        st = '0;
        case (op)
            cdq_pkg::OP_INS_FRONT: begin
                if (!was_full) begin
                    slot_mem[front_ptr] = val;
                    front_ptr = slot_before(front_ptr);
                    st.ok = 1'b1;
                end
            end
            cdq_pkg::OP_INS_REAR: begin
                if (!was_full) begin
                    rear_ptr = slot_after(rear_ptr);
                    slot_mem[rear_ptr] = val;
                    st.ok = 1'b1;
                end
            end
            cdq_pkg::OP_DEL_FRONT: begin
                if (!was_empty) begin
                    front_ptr = slot_after(front_ptr);
                    st.ok = 1'b1;
                end
            end
            cdq_pkg::OP_DEL_REAR: begin
                if (!was_empty) begin
                    rear_ptr = slot_before(rear_ptr);
                    st.ok = 1'b1;
                end
            end
            cdq_pkg::OP_PEEK: begin
                st.ok = 1'b1;
            end
            default: begin
            end
        endcase
        st.is_empty    = (front_ptr == rear_ptr);
        st.is_full     = (slot_after(rear_ptr) == front_ptr);
        st.front_value = st.is_empty ? EMPTY_VALUE : slot_mem[slot_after(front_ptr)];
        st.rear_value  = st.is_empty ? EMPTY_VALUE : slot_mem[rear_ptr];
        expected_status_q.push_back(st);
    endfunction

    function string fmt(deque_status_t st);
        return $sformatf("ok=%0b front=%h rear=%h empty=%0b full=%0b",
                         st.ok, st.front_value, st.rear_value, st.is_empty, st.is_full);
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // compare a result transfer with the oldest pending status
    function void check_result(deque_status_t got);
        deque_status_t want;
        if (expected_status_q.size() == 0) begin
            report($sformatf("result with nothing pending: %s", fmt(got)));
            return;
        end
        want = expected_status_q.pop_front();
        if (got.ok !== want.ok || got.front_value !== want.front_value ||
            got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
            got.is_full !== want.is_full) begin
            report($sformatf("expected %s, got %s", fmt(want), fmt(got)));
        end
    endfunction
endclass

module tb_circular_deque;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  REG_CAPACITY     = 3'd0;
    localparam logic [2:0]  OP_CODE_MAX      = 3'd7;
    localparam logic [10:0] CAP_FIELD_MAX    = 11'h7FF;
    localparam logic [31:0] VAL_MIN          = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ZERO         = 32'h0000_0000;
    localparam logic [31:0] VAL_MINUS_ONE    = 32'hFFFF_FFFF;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          PHASE_COUNT      = 12;
    localparam int          ITEMS_PER_PHASE  = 100;
    localparam int          PRESSURE_PHASE   = 3;
    localparam int          SETTLE_CYCLES    = 6;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deque_scoreboard sb;
    bit              src_gaps_on;
    bit              sink_stalls_on;
    bit              hold_out_req;

    circular_deque u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one operation transfer on the input stream, with an optional gap first
    task automatic send_op(logic [2:0] op, logic [31:0] val);
        int unsigned gap = src_gaps_on ? $urandom_range(16, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, op};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_op(op, val);
    endtask

    // result side: random stalls, one long hold-off on request
    task automatic drain_results();
        int unsigned stall;
        forever begin
            if (hold_out_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_out_req = 1'b0;
            end else begin
                stall = sink_stalls_on ? $urandom_range(16, 0) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(deque_status_t'(m_tdata[66:0]));
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // read capacity back and compare with what was last written
    task automatic check_capacity_reg(logic [10:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_CAPACITY;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== {21'b0, want})
            sb.report($sformatf("capacity read: expected %h, got %h", {21'b0, want}, got));
    endtask

    // wait for every pending result, then let the pipeline go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (sb.expected_status_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [10:0] cap);
        settle_block();
        apb_write(REG_CAPACITY, {21'b0, cap});
        sb.set_capacity(cap);
        check_capacity_reg(cap);
    endtask

    // mostly inserts or deletes by the phase bias, a few peeks and unknown codes
    function automatic logic [2:0] pick_op(int unsigned ins_pct);
        int unsigned r = $urandom_range(99, 0);
        if (r < 2) return 3'($urandom_range(OP_CODE_MAX, cdq_pkg::OP_PEEK + 1));
        if (r < 6) return cdq_pkg::OP_PEEK;
        if ($urandom_range(99, 0) < ins_pct)
            return $urandom_range(1, 0) ? cdq_pkg::OP_INS_FRONT : cdq_pkg::OP_INS_REAR;
        return $urandom_range(1, 0) ? cdq_pkg::OP_DEL_FRONT : cdq_pkg::OP_DEL_REAR;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15, 0))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_ZERO;
            3: return VAL_MINUS_ONE;
            default: return $urandom;
        endcase
    endfunction

    // watchdog
    initial begin
        #(3_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [10:0] cap;
        int unsigned ins_pct;
        sb = new();
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        hold_out_req   = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            drain_results();
        join_none

        // reset capacity, empty deque refusals, unknown codes, extreme values
        check_capacity_reg(11'(cdq_pkg::DEPTH));
        send_op(cdq_pkg::OP_PEEK, VAL_MAX);
        send_op(cdq_pkg::OP_DEL_FRONT, VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_REAR, VAL_ZERO);
        send_op(3'(cdq_pkg::OP_PEEK + 1), VAL_MIN);
        send_op(OP_CODE_MAX, VAL_MINUS_ONE);
        send_op(cdq_pkg::OP_INS_FRONT, VAL_MIN);
        send_op(cdq_pkg::OP_INS_REAR, VAL_MAX);
        send_op(cdq_pkg::OP_INS_FRONT, VAL_ZERO);
        send_op(cdq_pkg::OP_INS_REAR, VAL_MINUS_ONE);
        send_op(3'(OP_CODE_MAX - 1), VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_FRONT, VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_REAR, VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_FRONT, VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_REAR, VAL_ZERO);
        send_op(cdq_pkg::OP_INS_REAR, 32'h0000_0001);
        send_op(cdq_pkg::OP_DEL_FRONT, VAL_ZERO);

        // capacity zero behaves as one: full after a single insert
        write_capacity(11'd0);
        send_op(cdq_pkg::OP_INS_FRONT, 32'h5A5A_A5A5);
        send_op(cdq_pkg::OP_INS_REAR, VAL_MAX);
        send_op(cdq_pkg::OP_INS_FRONT, VAL_MIN);
        send_op(cdq_pkg::OP_PEEK, VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_REAR, VAL_ZERO);
        send_op(cdq_pkg::OP_DEL_FRONT, VAL_ZERO);
        send_op(cdq_pkg::OP_INS_REAR, 32'hA5A5_5A5A);
        send_op(cdq_pkg::OP_DEL_FRONT, VAL_ZERO);

        // random phases, each with its own capacity, bias and idling mode
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: cap = 11'd2;
                1: cap = CAP_FIELD_MAX;
                2: cap = 11'd1;
                default: begin
                    if ($urandom_range(4, 0) == 0) cap = 11'($urandom_range(2047, 0));
                    else cap = 11'($urandom_range(16, 1));
                end
            endcase
            write_capacity(cap);
            ins_pct        = 30 + 20 * $urandom_range(2, 0);
            src_gaps_on    = ($urandom_range(3, 0) != 0);
            sink_stalls_on = ($urandom_range(3, 0) != 0);
            if (phase == PRESSURE_PHASE) begin
                src_gaps_on  = 1'b0;
                hold_out_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_op(pick_op(ins_pct), pick_value());
        end

        // wind down
        s_tvalid <= 1'b0;
        while (sb.expected_status_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_status_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/circular_deque.sv
sv/cdq_check.sv
tb/tb_circular_deque.sv
